// ===== design/sfd_pkg.sv =====
// Serial frame deframer package: phase encoding, item structs and constants.
// No dependencies; used by every other file of the block except sfd_stream_if.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    typedef enum logic [3:0] {
        PH_HUNT = 4'd0,
        PH_LEN  = 4'd1,
        PH_ID   = 4'd2,
        PH_ACK  = 4'd3,
        PH_ENC  = 4'd4,
        PH_IDX  = 4'd5,
        PH_DATA = 4'd6,
        PH_CRC  = 4'd7,
        PH_IDLE = 4'd8
    } phase_t;

    localparam logic [7:0] START_MARKER_RESET = 8'h2B;
    // length byte counts the header and CRC overhead beyond the data run
    localparam logic [8:0] LEN_BIAS           = 9'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] byte_index;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic      hit;
        out_item_t item;
    } parse_res_t;

endpackage

`default_nettype wire

// ===== design/sfd_stream_if.sv =====
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; payload types come from sfd_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface sfd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sfd_in_reg.sv =====
// Input register stage: holds one accepted byte until the parser consumes it.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire sfd_pkg::in_item_t in_item,
    output logic                  in_ready,
    input  wire logic             adv,
    output logic                  s1_valid,
    output sfd_pkg::in_item_t     s1_item
);
    import sfd_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_ready = !valid_reg || adv;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (adv)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// ===== design/sfd_parser.sv =====
// Frame parser: phase, byte count and length state plus the per-byte decision.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       start_marker,
    input  wire sfd_pkg::in_item_t s1_item,
    input  wire logic             adv,
    output sfd_pkg::parse_res_t   res
);
    import sfd_pkg::*;

    phase_t     phase_reg, phase_next, phase_eff;
    logic [7:0] count_reg, count_next, count_eff;
    logic [7:0] len_reg, len_next;
    logic       more_data;

    // restart clears the parser before the byte is looked at
    assign phase_eff = s1_item.restart ? PH_HUNT : phase_reg;
    assign count_eff = s1_item.restart ? 8'd0 : count_reg;

    // byte_count < length - 2, signed, done as an unsigned 9-bit compare
    assign more_data = ({1'b0, count_eff} + LEN_BIAS) < {1'b0, len_reg};

    always_comb
    begin
        phase_next               = phase_eff;
        len_next                 = len_reg;
        res.hit                  = 1'b1;
        res.item.frame_byte      = s1_item.rx_byte;
        res.item.byte_index      = count_eff;
        res.item.frame_end       = 1'b0;
        case (phase_eff)
            PH_HUNT:
            begin
                if (s1_item.rx_byte == start_marker)
                    phase_next = PH_LEN;
                else
                    res.hit = 1'b0;
            end
            PH_LEN:
            begin
                len_next   = s1_item.rx_byte;
                phase_next = PH_ID;
            end
            PH_ID:   phase_next = PH_ACK;
            PH_ACK:  phase_next = PH_ENC;
            PH_ENC:  phase_next = PH_IDX;
            PH_IDX:  phase_next = PH_DATA;
            PH_DATA:
            begin
                if (!more_data)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                res.item.frame_end = 1'b1;
                phase_next         = PH_IDLE;
            end
            default:
            begin
                res.hit    = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
        count_next = res.hit ? count_eff + 8'd1 : count_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= 8'd0;
            len_reg   <= 8'd0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfd_out_reg.sv =====
// Output register: holds one result until the consumer takes it.
// Depends on sfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire sfd_pkg::out_item_t load_item,
    output logic                  free,
    output logic                  out_valid,
    output sfd_pkg::out_item_t    out_item,
    input  wire logic             out_ready
);
    import sfd_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== design/serial_frame_deframer.sv =====
// Serial frame deframer top level: input register, parser, output register.
// Depends on sfd_pkg, sfd_stream_if, sfd_in_reg, sfd_parser, sfd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

// Hunts the byte stream for the start marker, then passes on the marker, five
// header bytes (length, id, ack/nack, encryption flag, index), the data bytes
// and the CRC byte, each tagged with its position in the frame; the CRC byte
// carries frame_end. Bytes outside a frame produce no transfer on egress;
// after the CRC the block ignores bytes until one arrives with restart set.
// One byte is accepted per clock while egress keeps up: a byte sits in the
// input register while the parser decides on it, then its result is loaded into
// the output register and is valid on egress from there. While a result waits
// on egress the input register still takes one more byte; if that byte also
// produces a result, ingress stalls until egress drains. Ignored bytes never
// stall. Users write the start marker over cfg between frames; no logic checks it.
module serial_frame_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfd_stream_if.sink   ingress,
    sfd_stream_if.source egress,
    sfd_stream_if.sink   cfg
);
    import sfd_pkg::*;

    logic [7:0] marker_reg;
    logic       s1_valid;
    in_item_t   s1_item;
    parse_res_t res;
    logic       out_free;
    logic       adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= START_MARKER_RESET;
        else if (cfg.valid)
            marker_reg <= cfg.data;
    end

    // dropped bytes move on even while egress is stalled
    assign adv = s1_valid && (out_free || !res.hit);

    sfd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ingress.valid),
        .in_item  (ingress.data),
        .in_ready (ingress.ready),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    sfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_marker (marker_reg),
        .s1_item      (s1_item),
        .adv          (adv),
        .res          (res)
    );

    sfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && res.hit),
        .load_item (res.item),
        .free      (out_free),
        .out_valid (egress.valid),
        .out_item  (egress.data),
        .out_ready (egress.ready)
    );

    // the CRC byte never comes before the marker, five header bytes and one data byte
    a_end_position: assert property (@(posedge clk) disable iff (!rst_n)
        egress.valid && egress.data.frame_end |-> egress.data.byte_index >= 8'd7)
        else $error("frame end at impossible position");

    // a captured byte reaches the egress register in the next cycle
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res.hit |=> egress.valid)
        else $error("captured byte lost");

    // an empty input register never blocks ingress
    a_ingress_open: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid |-> ingress.ready)
        else $error("ingress blocked while input stage empty");

    // the marker always opens a frame at position zero
    a_marker_first: assert property (@(posedge clk) disable iff (!rst_n)
        adv && res.hit && res.item.byte_index == 8'd0 |-> res.item.frame_byte == marker_reg)
        else $error("position zero is not the marker");

endmodule

`default_nettype wire
